>>> rtl/core/bxpd_pkg.sv
// ----------------------------------------------------------------------------
// bxpd_pkg: shared types and constants
// Result queue entry, configuration bundle, queue status and register indexes
// for the binarized XNOR-popcount dot product.
// ----------------------------------------------------------------------------
package bxpd_pkg;

  localparam int SumW   = 14;
  localparam int ActW   = 16;
  localparam int ScaleW = 16;
  localparam int ShiftW = 24;
  localparam int ResW   = 32;
  localparam int ProdW  = SumW + ScaleW;

  localparam int CfgIdxW = 8;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SCALE_EN = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_RELU_EN  = 8'd1;

  // Depth of the queue between the front and the back.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic signed [SumW-1:0]   raw_sum;
    logic signed [ScaleW-1:0] scale;
    logic signed [ShiftW-1:0] shift;
  } bxpd_entry_t;

  typedef struct packed {
    logic scale_en;
    logic relu_en;
  } bxpd_cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bxpd_qstat_t;

endpackage

>>> rtl/core/bxpd_front.sv
// ----------------------------------------------------------------------------
// bxpd_front: binarize and accumulate
// Takes one element per cycle unless the queue is full, keeps the saturating
// +1/-1 agreement count and pushes it, with scale and shift, on the last item.
// ----------------------------------------------------------------------------
module bxpd_front #(
  parameter int MAX_DOT_LENGTH = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [bxpd_pkg::ActW-1:0]   activation_i,
  input  logic signed [bxpd_pkg::ActW-1:0]   threshold_i,
  input  logic                               weight_bit_i,
  input  logic signed [bxpd_pkg::ScaleW-1:0] scale_i,
  input  logic signed [bxpd_pkg::ShiftW-1:0] shift_i,
  input  logic                               last_i,
  input  bxpd_pkg::bxpd_qstat_t              qstat_i,
  output logic                               push_o,
  output bxpd_pkg::bxpd_entry_t              entry_o
);
  import bxpd_pkg::*;

  localparam int SumBound = (MAX_DOT_LENGTH < 8191) ? MAX_DOT_LENGTH : 8191;
  localparam logic signed [SumW:0] BoundPos = (SumW + 1)'(SumBound);
  localparam logic signed [SumW:0] BoundNeg = -BoundPos;

  logic signed [SumW-1:0] running_q, running_d;
  logic signed [SumW:0]   step_sum;
  logic signed [SumW-1:0] sat_sum;
  logic                   act_bit;
  logic                   accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i & ~qstat_i.full;
  assign act_bit    = (activation_i >= threshold_i);

  always_comb begin
    step_sum = (SumW + 1)'(running_q) +
               ((act_bit == weight_bit_i) ? (SumW + 1)'(1) : -(SumW + 1)'(1));
    if (step_sum > BoundPos) begin
      sat_sum = BoundPos[SumW-1:0];
    end else if (step_sum < BoundNeg) begin
      sat_sum = BoundNeg[SumW-1:0];
    end else begin
      sat_sum = step_sum[SumW-1:0];
    end
  end

  always_comb begin
    running_d = running_q;
    if (accept) begin
      running_d = last_i ? '0 : sat_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
    end else begin
      running_q <= running_d;
    end
  end

  assign push_o          = accept & last_i;
  assign entry_o.raw_sum = sat_sum;
  assign entry_o.scale   = scale_i;
  assign entry_o.shift   = shift_i;

  // The count restarts from zero after every finished dot product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (running_q == '0))
    else $error("running sum not cleared after last item");

endmodule

>>> rtl/core/bxpd_queue.sv
// ----------------------------------------------------------------------------
// bxpd_queue: result queue
// Small register queue of finished counts between the front and the back.
// ----------------------------------------------------------------------------
module bxpd_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bxpd_pkg::bxpd_entry_t entry_i,
  input  logic                  pop_i,
  output bxpd_pkg::bxpd_entry_t entry_o,
  output bxpd_pkg::bxpd_qstat_t qstat_o
);
  import bxpd_pkg::*;

  bxpd_entry_t           mem_q [QDepth];
  logic [QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]      count_q, count_d;

  assign qstat_o.full  = (count_q == QCntW'(QDepth));
  assign qstat_o.empty = (count_q == '0);
  assign entry_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !qstat_o.full)
    else $error("push into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !qstat_o.empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/bxpd_back.sv
// ----------------------------------------------------------------------------
// bxpd_back: scale, shift and clamp
// Two-stage pipeline: multiply by the channel scale, then add the shift and
// saturate (or count << 8 unscaled), ReLU if enabled, into output register.
// ----------------------------------------------------------------------------
module bxpd_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bxpd_pkg::bxpd_cfg_t              cfg_i,
  input  bxpd_pkg::bxpd_qstat_t            qstat_i,
  input  bxpd_pkg::bxpd_entry_t            entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [bxpd_pkg::SumW-1:0] raw_sum_o,
  output logic signed [bxpd_pkg::ResW-1:0] result_o
);
  import bxpd_pkg::*;

  localparam logic signed [ResW:0] ResMax = (ResW + 1)'({1'b0, {(ResW - 1){1'b1}}});
  localparam logic signed [ResW:0] ResMin = -ResMax - (ResW + 1)'(1);

  // Multiply stage.
  logic                     a_vld_q;
  logic signed [SumW-1:0]   a_raw_q;
  logic signed [ProdW-1:0]  a_prod_q;
  logic signed [ShiftW-1:0] a_shift_q;
  logic signed [ProdW-1:0]  prod;

  // Output stage.
  logic                     o_vld_q;
  logic signed [SumW-1:0]   o_raw_q;
  logic signed [ResW-1:0]   o_res_q;
  logic signed [ResW:0]     wide_sum;
  logic signed [ResW-1:0]   res_d;

  logic o_en, a_en;

  assign o_en  = !o_vld_q || !out_stall_i;
  assign a_en  = !a_vld_q || o_en;
  assign pop_o = a_en && !qstat_i.empty;

  assign prod = ProdW'(entry_i.raw_sum) * ProdW'(entry_i.scale);

  always_comb begin
    wide_sum = (ResW + 1)'(a_prod_q) + (ResW + 1)'(a_shift_q);
    if (cfg_i.scale_en) begin
      if (wide_sum > ResMax) begin
        res_d = ResMax[ResW-1:0];
      end else if (wide_sum < ResMin) begin
        res_d = ResMin[ResW-1:0];
      end else begin
        res_d = wide_sum[ResW-1:0];
      end
    end else begin
      res_d = {{(ResW - SumW - 8){a_raw_q[SumW-1]}}, a_raw_q, 8'b0};
    end
    if (cfg_i.relu_en && res_d[ResW-1]) begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_en) begin
        a_vld_q <= !qstat_i.empty;
      end
      if (o_en) begin
        o_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_raw_q   <= entry_i.raw_sum;
      a_prod_q  <= prod;
      a_shift_q <= entry_i.shift;
    end
    if (o_en && a_vld_q) begin
      o_raw_q <= a_raw_q;
      o_res_q <= res_d;
    end
  end

  assign out_valid_o = o_vld_q;
  assign raw_sum_o   = o_raw_q;
  assign result_o    = o_res_q;

  // A held multiply stage must not be overwritten while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vld_q && o_vld_q && out_stall_i) |-> !pop_o)
    else $error("multiply stage overwritten under stall");

endmodule

>>> rtl/core/binarized_xnor_popcount_dot_top.sv
// ----------------------------------------------------------------------------
// binarized_xnor_popcount_dot_top: binarized XNOR-popcount dot product
// Streams patch elements, adds +1 per weight match and -1 per mismatch, and
// emits the raw count and a result, optionally scaled/shifted and rectified.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                 Payload
//   -------  ---------  ------------------------  ---------------------------
//   in       sink       in_valid_i / in_stall_o   activation, threshold,
//                                                 weight_bit, scale, shift, last
//   out      source     out_valid_o / out_stall_i raw_sum, result
//   cfg      sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One element is accepted every cycle while the result queue is not full; the
// agreement count is a single saturating add in the front, so the accumulate
// loop sets the rate. After its last item is accepted, a result passes through
// the queue entry and the multiply stage into the output register.
// Reset clears the count, the queue, the pipeline valids and both
// configuration bits; there is no clearing pass.
// The input stalls only while the four-entry result queue is full, so the
// output side can stall for several results without holding up elements.
//
module binarized_xnor_popcount_dot_top #(
  parameter int MAX_DOT_LENGTH = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Element stream.
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [bxpd_pkg::ActW-1:0]    activation_i,
  input  logic signed [bxpd_pkg::ActW-1:0]    threshold_i,
  input  logic                                weight_bit_i,
  input  logic signed [bxpd_pkg::ScaleW-1:0]  scale_i,
  input  logic signed [bxpd_pkg::ShiftW-1:0]  shift_i,
  input  logic                                last_i,
  // Result stream.
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bxpd_pkg::SumW-1:0]    raw_sum_o,
  output logic signed [bxpd_pkg::ResW-1:0]    result_o,
  // Configuration writes.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bxpd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic                                cfg_data_i
);
  import bxpd_pkg::*;

  bxpd_cfg_t   cfg_q, cfg_d;
  bxpd_qstat_t qstat;
  bxpd_entry_t push_entry, head_entry;
  logic        push, pop;

  // Configuration is a pair of single-bit registers; writes to any other
  // index are accepted and dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCALE_EN: cfg_d.scale_en = cfg_data_i;
        CFG_RELU_EN:  cfg_d.relu_en  = cfg_data_i;
        default:      cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: binarize each element and keep the running agreement count.
  bxpd_front #(
    .MAX_DOT_LENGTH (MAX_DOT_LENGTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .activation_i (activation_i),
    .threshold_i  (threshold_i),
    .weight_bit_i (weight_bit_i),
    .scale_i      (scale_i),
    .shift_i      (shift_i),
    .last_i       (last_i),
    .qstat_i      (qstat),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  // Queue of finished counts, each with the scale and shift of its channel.
  bxpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (head_entry),
    .qstat_o (qstat)
  );

  // Back: optionally scale, shift and saturate, optionally rectify, then present the result.
  bxpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .raw_sum_o   (raw_sum_o),
    .result_o    (result_o)
  );

endmodule
